// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== design/sst_pkg.sv =====
package sst_pkg;

    localparam int SIDE_W    = 7;
    localparam int SQ_W      = 2 * SIDE_W;
    localparam int SIZE_W    = 3 * SIDE_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [SIDE_W-1:0] RESET_SIDE   = 7'd8;
    localparam logic [SIDE_W-1:0] RESET_BLOCKS = 7'd1;
    localparam logic [SQ_W-1:0]   RESET_SQ     = 14'd64;
    localparam logic [SQ_W-1:0]   RESET_ROWLEN = 14'd8;
    localparam logic [SIZE_W-1:0] RESET_SIZE   = 21'd64;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_LOAD_OVERFLOW = 2'd1,
        ST_NO_FRAME      = 2'd2
    } status_t;

    // What the back end does with one queued transaction.
    typedef enum logic [1:0] {
        OP_STORE     = 2'd0,
        OP_FETCH     = 2'd1,
        OP_LOAD_ERR  = 2'd2,
        OP_DRAIN_ERR = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } sst_ctrl_t;

endpackage

// ===== design/segmented_square_transpose.sv =====
// Channel   Direction  Payload
// s_*       in         tdata: elem_value; tuser: action (0 load, 1 drain)
// m_*       out        tdata: out_value; tlast: frame_last; tuser: status
// cfg_*     in         cfg_index: 0 side_length, 1 block_count; cfg_data: value
//
// One transaction per cycle is sustained on both streams while the output is
// ready and no geometry update is in progress; a result passes through the
// queue and then the buffer read register. A two-entry queue between front and back lets either side stall.
// After a register write the input is held off while the frame geometry is
// recomputed. Reset clears all control state; buffer contents are undefined
// until written.
module segmented_square_transpose
    import sst_pkg::*;
#(
    parameter int MAX_ELEMS  = 4096,
    parameter int MAX_SIDE   = 64,
    parameter int ELEM_WIDTH = 64,
    localparam int TDATA_W   = ((ELEM_WIDTH + 7) / 8) * 8,
    localparam int ADDR_W    = $clog2(MAX_ELEMS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,    // [ELEM_WIDTH-1:0] elem_value
    input  logic [0:0]           s_tuser,    // [0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,    // [ELEM_WIDTH-1:0] out_value
    output logic                 m_tlast,
    output logic [1:0]           m_tuser,    // [1:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIDE_W-1:0]    cfg_data
);

    localparam int CMD_W = $bits(sst_ctrl_t) + ADDR_W + ELEM_WIDTH;

    logic                  fq_valid;
    logic                  fq_ready;
    sst_ctrl_t             fq_ctrl;
    logic [ADDR_W-1:0]     fq_addr;
    logic [ELEM_WIDTH-1:0] fq_data;
    logic                  qb_valid;
    logic                  qb_ready;
    logic [CMD_W-1:0]      qb_word;
    sst_ctrl_t             qb_ctrl;
    logic [ADDR_W-1:0]     qb_addr;
    logic [ELEM_WIDTH-1:0] qb_data;
    logic [ELEM_WIDTH-1:0] out_value;
    status_t               out_status;

    sst_front #(
        .MAX_ELEMS  (MAX_ELEMS),
        .MAX_SIDE   (MAX_SIDE),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser[0]),
        .in_value  (s_tdata[ELEM_WIDTH-1:0]),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_ctrl  (fq_ctrl),
        .cmd_addr  (fq_addr),
        .cmd_data  (fq_data)
    );

    sst_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_ctrl, fq_addr, fq_data}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_word)
    );

    assign {qb_ctrl, qb_addr, qb_data} = qb_word;

    sst_back #(
        .MAX_ELEMS  (MAX_ELEMS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (qb_valid),
        .cmd_ready  (qb_ready),
        .cmd_ctrl   (qb_ctrl),
        .cmd_addr   (qb_addr),
        .cmd_data   (qb_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_last   (m_tlast),
        .out_status (out_status)
    );

    assign m_tdata = TDATA_W'(out_value);
    assign m_tuser = out_status;

endmodule

// ===== design/sst_front.sv =====
`include "assert_macros.svh"

module sst_front
    import sst_pkg::*;
#(
    parameter int MAX_ELEMS  = 4096,
    parameter int MAX_SIDE   = 64,
    parameter int ELEM_WIDTH = 64,
    localparam int ADDR_W    = $clog2(MAX_ELEMS),
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIDE_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_action,
    input  logic [ELEM_WIDTH-1:0] in_value,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output sst_ctrl_t             cmd_ctrl,
    output logic [ADDR_W-1:0]     cmd_addr,
    output logic [ELEM_WIDTH-1:0] cmd_data
);

    localparam logic RESET_GEOM_OK = (int'(RESET_SIDE) <= MAX_SIDE)
                                  && (int'(RESET_SIZE) <= MAX_ELEMS);

    logic [SIDE_W-1:0] side_reg;
    logic [SIDE_W-1:0] blocks_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   rowlen_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              geom_ok_reg;
    logic [1:0]        geom_cnt_reg;

    logic [CNT_W-1:0]  load_cnt_reg,  load_cnt_next;
    logic              full_reg,      full_next;
    logic [SIDE_W-1:0] row_reg,       row_next;
    logic [SIDE_W-1:0] blk_reg,       blk_next;
    logic [SIDE_W-1:0] col_reg,       col_next;
    logic [ADDR_W-1:0] base_reg,      base_next;
    logic [ADDR_W-1:0] addr_reg,      addr_next;

    logic cfg_we;
    logic geom_idle;
    logic accept;
    logic load_ok;
    logic drain_ok;
    logic last_col;
    logic last_blk;
    logic last_row;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign geom_idle = (geom_cnt_reg == 2'd0);
    assign in_ready  = cmd_ready && geom_idle;
    assign cmd_valid = in_valid && geom_idle;
    assign accept    = in_valid && in_ready;
    assign cmd_data  = in_value;

    // Geometry is derived in steps after a register write (square and row length,
    // then frame size, then validity); the front end holds off transactions until it has settled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= RESET_SIDE;
            blocks_reg   <= RESET_BLOCKS;
            sq_reg       <= RESET_SQ;
            rowlen_reg   <= RESET_ROWLEN;
            size_reg     <= RESET_SIZE;
            geom_ok_reg  <= RESET_GEOM_OK;
            geom_cnt_reg <= 2'd0;
        end
        else
        begin
            if (geom_cnt_reg == 2'd3)
            begin
                sq_reg     <= SQ_W'(side_reg) * SQ_W'(side_reg);
                rowlen_reg <= SQ_W'(side_reg) * SQ_W'(blocks_reg);
            end
            if (geom_cnt_reg == 2'd2)
            begin
                size_reg <= SIZE_W'(sq_reg) * SIZE_W'(blocks_reg);
            end
            if (geom_cnt_reg == 2'd1)
            begin
                geom_ok_reg <= (side_reg != '0) && (int'(side_reg) <= MAX_SIDE)
                            && (blocks_reg != '0) && (int'(size_reg) <= MAX_ELEMS);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIDE_LENGTH: side_reg   <= cfg_data;
                    REG_BLOCK_COUNT: blocks_reg <= cfg_data;
                    default:         ;
                endcase
                geom_cnt_reg <= 2'd3;
            end
            else if (!geom_idle)
            begin
                geom_cnt_reg <= geom_cnt_reg - 2'd1;
            end
        end
    end

    assign load_ok  = geom_ok_reg && !full_reg && (SIZE_W'(load_cnt_reg) < size_reg);
    assign drain_ok = geom_ok_reg && full_reg;
    assign last_col = (col_reg == side_reg - 7'd1);
    assign last_blk = (blk_reg == blocks_reg - 7'd1);
    assign last_row = (row_reg == side_reg - 7'd1);

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        full_next     = full_reg;
        row_next      = row_reg;
        blk_next      = blk_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        addr_next     = addr_reg;
        cmd_ctrl.last = 1'b0;

        if (in_action == ACT_LOAD)
        begin
            cmd_ctrl.op = load_ok ? OP_STORE : OP_LOAD_ERR;
            cmd_addr    = load_cnt_reg[ADDR_W-1:0];
        end
        else
        begin
            cmd_ctrl.op = drain_ok ? OP_FETCH : OP_DRAIN_ERR;
            cmd_addr    = addr_reg;
        end

        // Drain walks the buffer column-major inside each block; the read
        // address is kept incrementally so no multiplier sits on this path.
        if (in_action == ACT_DRAIN && drain_ok)
        begin
            cmd_ctrl.last = last_col && last_blk && last_row;
        end

        if (accept)
        begin
            if (in_action == ACT_LOAD && load_ok)
            begin
                load_cnt_next = load_cnt_reg + CNT_W'(1);
                if (SIZE_W'(load_cnt_reg) + SIZE_W'(1) == size_reg)
                begin
                    full_next = 1'b1;
                end
            end
            else if (in_action == ACT_DRAIN && drain_ok)
            begin
                if (!last_col)
                begin
                    col_next  = col_reg + 7'd1;
                    addr_next = addr_reg + ADDR_W'(rowlen_reg);
                end
                else if (!last_blk)
                begin
                    col_next  = '0;
                    blk_next  = blk_reg + 7'd1;
                    base_next = base_reg + ADDR_W'(side_reg);
                    addr_next = base_reg + ADDR_W'(side_reg);
                end
                else if (!last_row)
                begin
                    col_next  = '0;
                    blk_next  = '0;
                    row_next  = row_reg + 7'd1;
                    base_next = ADDR_W'(row_reg) + ADDR_W'(1);
                    addr_next = ADDR_W'(row_reg) + ADDR_W'(1);
                end
                else
                begin
                    load_cnt_next = '0;
                    full_next     = 1'b0;
                    row_next      = '0;
                    blk_next      = '0;
                    col_next      = '0;
                    base_next     = '0;
                    addr_next     = '0;
                end
            end
        end

        // Any register write abandons the frame in progress.
        if (cfg_we)
        begin
            load_cnt_next = '0;
            full_next     = 1'b0;
            row_next      = '0;
            blk_next      = '0;
            col_next      = '0;
            base_next     = '0;
            addr_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            full_reg     <= 1'b0;
            row_reg      <= '0;
            blk_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            addr_reg     <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            full_reg     <= full_next;
            row_reg      <= row_next;
            blk_reg      <= blk_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            addr_reg     <= addr_next;
        end
    end

    `ASSERT_ALWAYS(a_full_count, clk, rst_n, full_reg |-> (SIZE_W'(load_cnt_reg) == size_reg), "frame held without a full load count")
    `ASSERT_ALWAYS(a_idle_drain, clk, rst_n, !full_reg |-> (row_reg == '0 && blk_reg == '0 && col_reg == '0 && addr_reg == '0), "drain position moved without a frame")
    `ASSERT_ALWAYS(a_drain_range, clk, rst_n, (full_reg && geom_idle) |-> (col_reg < side_reg && row_reg < side_reg && blk_reg < blocks_reg), "drain position outside the geometry")

endmodule

// ===== design/sst_queue.sv =====
`include "assert_macros.svh"

module sst_queue
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam logic [1:0] FULL_COUNT = 2'd2;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_COUNT);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_COUNT, "queue count beyond its depth")
    `ASSERT_ALWAYS(a_ptr_track, clk, rst_n, (count_reg == 2'd0 || count_reg == FULL_COUNT) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")

endmodule

// ===== design/sst_back.sv =====
`include "assert_macros.svh"

module sst_back
    import sst_pkg::*;
#(
    parameter int MAX_ELEMS  = 4096,
    parameter int ELEM_WIDTH = 64,
    localparam int ADDR_W    = $clog2(MAX_ELEMS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  sst_ctrl_t             cmd_ctrl,
    input  logic [ADDR_W-1:0]     cmd_addr,
    input  logic [ELEM_WIDTH-1:0] cmd_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ELEM_WIDTH-1:0] out_value,
    output logic                  out_last,
    output status_t               out_status
);

    logic [ELEM_WIDTH-1:0] frame_mem [MAX_ELEMS];
    logic [ELEM_WIDTH-1:0] rdata_reg;
    logic                  valid_reg,  valid_next;
    logic                  fetch_reg;
    logic                  last_reg;
    status_t               status_reg, status_next;
    logic                  pop;

    assign cmd_ready  = !valid_reg || out_ready;
    assign pop        = cmd_valid && cmd_ready;
    assign valid_next = pop || (valid_reg && !out_ready);

    always_comb
    begin
        case (cmd_ctrl.op)
            OP_STORE:     status_next = ST_OK;
            OP_FETCH:     status_next = ST_OK;
            OP_LOAD_ERR:  status_next = ST_LOAD_OVERFLOW;
            OP_DRAIN_ERR: status_next = ST_NO_FRAME;
            default:      status_next = ST_OK;
        endcase
    end

    // Loads and drains reach the buffer in arrival order, so a new frame
    // can never overwrite a word that an earlier drain still has to read.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cmd_ctrl.op == OP_STORE)
            begin
                frame_mem[cmd_addr] <= cmd_data;
            end
            rdata_reg <= frame_mem[cmd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            fetch_reg  <= 1'b0;
            last_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                fetch_reg  <= (cmd_ctrl.op == OP_FETCH);
                last_reg   <= cmd_ctrl.last;
                status_reg <= status_next;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_value  = fetch_reg ? rdata_reg : '0;
    assign out_last   = last_reg;
    assign out_status = status_reg;

    `ASSERT_NEVER(a_last_ok, clk, rst_n, valid_reg && last_reg && status_reg != ST_OK, "frame end flagged on an error")
    `ASSERT_NEVER(a_fetch_ok, clk, rst_n, valid_reg && fetch_reg && status_reg != ST_OK, "buffer read reported with an error")
    `ASSERT_ALWAYS(a_last_fetch, clk, rst_n, (valid_reg && last_reg) |-> fetch_reg, "frame end on a transaction without a buffer read")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sst_pkg::*;

    localparam int FRAME_DEPTH    = 4096;
    localparam int SIDE_MAX       = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_WORDS   = 500;
    localparam int FIXED_PHASES   = 7;

    // No register lives at this index; a write to it only restarts the frame.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd15;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
        status_t     status;
    } word_result_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic                  act;
        logic [63:0]           arg;
        bit                    typed;
        word_result_t          want;
    } vector_row_t;

    localparam word_result_t RES_LOAD_OK  = '{64'd0, 1'b0, ST_OK};
    localparam word_result_t RES_OVERFLOW = '{64'd0, 1'b0, ST_LOAD_OVERFLOW};
    localparam word_result_t RES_NO_FRAME = '{64'd0, 1'b0, ST_NO_FRAME};
    localparam word_result_t RES_SINGLE   = '{ALL_ONES, 1'b1, ST_OK};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic                 m_tlast;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIDE_W-1:0]    cfg_data = '0;

    // Shadow of the block: geometry, frame buffer and frame counters.
    logic [63:0] word_store [0:FRAME_DEPTH-1];
    int          cur_side = 8;
    int          cur_blocks = 1;
    int          loads_done = 0;
    int          d_row = 0;
    int          d_blk = 0;
    int          d_col = 0;
    bit          frame_held = 1'b0;

    word_result_t pending_words [$];
    vector_row_t  directed_rows [$];
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           sent_items = 0;
    int           errors = 0;
    int           quiet_cycles = 0;

    segmented_square_transpose dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Number of words in one frame, or 0 when the geometry is not usable.
    function automatic int frame_elems();
        int n;
        if (cur_side < 1 || cur_side > SIDE_MAX || cur_blocks < 1)
            return 0;
        n = cur_side * cur_side * cur_blocks;
        return (n > FRAME_DEPTH) ? 0 : n;
    endfunction

    task automatic predict_transpose(input logic act, input logic [63:0] word,
                                     output word_result_t res);
        int size;
        int addr;
        size = frame_elems();
        res = RES_LOAD_OK;
        if (act == ACT_LOAD)
        begin
            if (size == 0 || frame_held || loads_done >= size)
                res.status = ST_LOAD_OVERFLOW;
            else
            begin
                word_store[loads_done] = word;
                loads_done++;
                if (loads_done == size)
                begin
                    frame_held = 1'b1;
                    d_row = 0;
                    d_blk = 0;
                    d_col = 0;
                end
            end
        end
        else if (size == 0 || !frame_held)
            res.status = ST_NO_FRAME;
        else
        begin
            addr = d_col * cur_side * cur_blocks + d_blk * cur_side + d_row;
            res.value = word_store[addr];
            d_col++;
            if (d_col >= cur_side)
            begin
                d_col = 0;
                d_blk++;
                if (d_blk >= cur_blocks)
                begin
                    d_blk = 0;
                    d_row++;
                    if (d_row >= cur_side)
                    begin
                        res.last = 1'b1;
                        loads_done = 0;
                        d_row = 0;
                        frame_held = 1'b0;
                    end
                end
            end
        end
    endtask

    // Holds the input back until every outstanding result has been taken.
    task automatic settle_outputs();
        if (pending_words.size() != 0)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (pending_words.size() != 0);
        end
    endtask

    task automatic push_item(input logic act, input logic [63:0] word,
                             input bit typed, input word_result_t typed_res);
        word_result_t res;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        predict_transpose(act, word, res);
        sent_items++;
        pending_words.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
        settle_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SIDE_LENGTH)
            cur_side = int'(val);
        else if (idx == REG_BLOCK_COUNT)
            cur_blocks = int'(val);
        // Any write abandons the frame; the stored words stay.
        loads_done = 0;
        d_row = 0;
        d_blk = 0;
        d_col = 0;
        frame_held = 1'b0;
    endtask

    task automatic run_phase(input int ph);
        int side;
        int blocks;
        int size;
        int frames;
        int cut;
        case (ph)
            0: begin side = 1;  blocks = 1;  end
            1: begin side = 1;  blocks = 64; end
            2: begin side = 65; blocks = 1;  end
            3: begin side = 2;  blocks = 16; end
            4: begin side = 64; blocks = 1;  end
            5: begin side = 5;  blocks = 0;  end
            6: begin side = 32; blocks = 5;  end
            default:
            begin
                side = $urandom_range(1, 6);
                blocks = $urandom_range(1, 4);
                if ($urandom_range(9) == 0)
                    side = $urandom_range(1) ? 0 : $urandom_range(SIDE_MAX + 1, 127);
            end
        endcase
        write_reg(REG_SIDE_LENGTH, side[SIDE_W-1:0]);
        write_reg(REG_BLOCK_COUNT, blocks[SIDE_W-1:0]);

        case (ph % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
            default: begin send_gap_pct = 29; recv_stall_pct = 29; end
        endcase

        size = frame_elems();
        if (size == 0)
        begin
            for (int i = 0; i < 24; i++)
                push_item(1'($urandom_range(1)), {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
            return;
        end

        frames = (size > 32) ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            // Now and then a frame is left unfinished for the next write to drop.
            cut = ($urandom_range(9) == 0) ? $urandom_range(size - 1) : size;
            // A frame of more than 256 words is only started; the next write drops it.
            if (size > 256)
                cut = 16;
            for (int i = 0; i < cut; i++)
            begin
                if ($urandom_range(19) == 0)
                    push_item(ACT_DRAIN, {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
                push_item(ACT_LOAD, {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
            end
            if (cut < size)
                break;
            if ($urandom_range(3) == 0)
                push_item(ACT_LOAD, {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
            if ($urandom_range(7) == 0)
                settle_outputs();
            for (int i = 0; i < size; i++)
                push_item(ACT_DRAIN, {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
            if ($urandom_range(7) == 0)
                push_item(ACT_DRAIN, {$urandom, $urandom}, 1'b0, RES_LOAD_OK);
        end
    endtask

    always @(posedge clk)
    begin
        word_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected transaction, out_value %h last %b status %0d",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata !== want.value)
                begin
                    $display("%0t: out_value expected %h, got %h", $time, want.value, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: frame_last expected %b, got %b", $time, want.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        vector_row_t row;
        int ph;

        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, 64'd0, 1'b1, RES_NO_FRAME});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, ALL_ONES, 1'b1, RES_LOAD_OK});
        directed_rows.push_back('{ROW_REG, REG_NONE, ACT_LOAD, 64'h7F, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_REG, REG_SIDE_LENGTH, ACT_LOAD, 64'd1, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, ALL_ONES, 1'b1, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, 64'd0, 1'b1, RES_OVERFLOW});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, 64'd0, 1'b1, RES_SINGLE});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, ALL_ONES, 1'b1, RES_NO_FRAME});
        directed_rows.push_back('{ROW_REG, REG_SIDE_LENGTH, ACT_LOAD, 64'd2, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, 64'h0123_4567_89AB_CDEF, 1'b0,
                                  RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, 64'd0, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, ALL_ONES, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, 64'h8000_0000_0000_0001, 1'b0,
                                  RES_LOAD_OK});
        for (int i = 0; i < 4; i++)
            directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, 64'd0, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_REG, REG_SIDE_LENGTH, ACT_LOAD, 64'd0, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, ALL_ONES, 1'b1, RES_OVERFLOW});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, 64'd0, 1'b1, RES_NO_FRAME});
        directed_rows.push_back('{ROW_REG, REG_SIDE_LENGTH, ACT_LOAD, 64'd127, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_REG, REG_BLOCK_COUNT, ACT_LOAD, 64'd127, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, 64'd0, 1'b1, RES_OVERFLOW});
        directed_rows.push_back('{ROW_REG, REG_SIDE_LENGTH, ACT_LOAD, 64'd64, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_REG, REG_BLOCK_COUNT, ACT_LOAD, 64'd0, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_DRAIN, 64'd0, 1'b1, RES_NO_FRAME});
        // A 64-wide square repeated twice no longer fits in the buffer.
        directed_rows.push_back('{ROW_REG, REG_BLOCK_COUNT, ACT_LOAD, 64'd2, 1'b0, RES_LOAD_OK});
        directed_rows.push_back('{ROW_ITEM, REG_NONE, ACT_LOAD, ALL_ONES, 1'b1, RES_OVERFLOW});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.arg[SIDE_W-1:0]);
            else
                push_item(row.act, row.arg, row.typed, row.want);
        end

        sent_items = 0;
        ph = 0;
        while (ph < FIXED_PHASES || sent_items < TARGET_WORDS)
        begin
            run_phase(ph);
            ph++;
        end

        settle_outputs();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
